// ----- hdl/mwd_pkg.sv -----
`timescale 1ns / 1ps
package mwd_pkg;

	// Route handling
	localparam int ROUTE_HOPS = 10;
	localparam int ROUTE_W = 30;
	localparam logic [ROUTE_W-1:0] ROUTE_MASK = (3 * ROUTE_HOPS >= ROUTE_W) ?
		{ROUTE_W{1'b1}} : ROUTE_W'((64'd1 << (3 * ROUTE_HOPS)) - 64'd1);
	localparam logic [2:0] LAST_WAYPOINT = 3'd4;

	// Angles in Q.12 and Q.16
	localparam logic signed [17:0] PI_Q12 = 18'sd12868;
	localparam logic signed [17:0] TWO_PI_Q12 = 18'sd25736;
	localparam logic signed [18:0] HALF_PI_Q16 = 19'sd102944;
	localparam logic signed [17:0] HEAD_TOL = 18'sd4;

	// Distances in squared Q.10 units
	localparam logic [33:0] ARRIVE_D2 = 34'd1;
	localparam logic [33:0] NEAR_D2 = 34'd10485;
	localparam logic signed [16:0] WAYPT = 17'sd2048;

	// Wheel kinematics
	localparam logic signed [31:0] K_TURN = 32'sd404750336;
	localparam logic signed [31:0] KIN_GAIN = 32'sd1000;
	localparam logic signed [35:0] SPEED_NUM = 36'sd37;
	localparam logic [32:0] DEN_TURN = 33'd2002060;
	localparam logic [32:0] DEN_TURN_NEAR = 33'd8008240;
	localparam logic [32:0] DEN_STILL = 33'd320000;
	localparam logic [32:0] DEN_STILL_NEAR = 33'd1280000;

	// Sequencer step counts (last count of each phase)
	localparam logic [5:0] CORDIC_LAST = 6'd15;
	localparam logic [5:0] MUL_LAST = 6'd10;
	localparam logic [5:0] SQRT_LAST = 6'd31;
	localparam logic [5:0] DIV_LAST = 6'd16;
	localparam logic [2:0] JOB_U1 = 3'd1;
	localparam logic [2:0] JOB_LAST = 3'd5;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_CORDIC,
		ST_HEAD,
		ST_MUL,
		ST_SQRT,
		ST_KIN1,
		ST_KIN2,
		ST_DPREP,
		ST_DIV,
		ST_DSTORE,
		ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CAPTURE,
		OP_LOAD,
		OP_CORDIC,
		OP_HEAD,
		OP_MUL,
		OP_SQRT,
		OP_KIN1,
		OP_KIN2,
		OP_DPREP,
		OP_DIV,
		OP_DSTORE,
		OP_EMIT
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [5:0] cnt;
		logic [2:0] job;
	} cmd_t;

	typedef struct packed {
		logic restart;
		logic arrived;
		logic out_busy;
	} sts_t;

	// CORDIC arctangent table, Q.16 radians.
	function automatic logic signed [18:0] atan_q16(input logic [3:0] i);
		logic signed [18:0] v;
		begin
			case (i)
				4'd0: v = 19'sd51472;
				4'd1: v = 19'sd30385;
				4'd2: v = 19'sd16055;
				4'd3: v = 19'sd8150;
				4'd4: v = 19'sd4091;
				4'd5: v = 19'sd2047;
				4'd6: v = 19'sd1024;
				4'd7: v = 19'sd512;
				4'd8: v = 19'sd256;
				4'd9: v = 19'sd128;
				4'd10: v = 19'sd64;
				4'd11: v = 19'sd32;
				4'd12: v = 19'sd16;
				4'd13: v = 19'sd8;
				4'd14: v = 19'sd4;
				4'd15: v = 19'sd2;
				default: v = 19'sd0;
			endcase
			return v;
		end
	endfunction

	function automatic logic signed [16:0] waypt_x(input logic [2:0] g);
		logic signed [16:0] v;
		begin
			case (g)
				3'd2: v = -WAYPT;
				3'd4: v = WAYPT;
				default: v = 17'sd0;
			endcase
			return v;
		end
	endfunction

	function automatic logic signed [16:0] waypt_y(input logic [2:0] g);
		logic signed [16:0] v;
		begin
			case (g)
				3'd1: v = WAYPT;
				3'd3: v = -WAYPT;
				default: v = 17'sd0;
			endcase
			return v;
		end
	endfunction

endpackage

// ----- hdl/mwd_ctrl.sv -----
`timescale 1ns / 1ps
module mwd_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  mwd_pkg::sts_t   sts,
	output mwd_pkg::cmd_t   cmd
);

	mwd_pkg::state_t state_q, state_d;
	logic [5:0] cnt_q, cnt_d;
	logic [2:0] job_q, job_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mwd_pkg::ST_IDLE;
			cnt_q   <= '0;
			job_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			job_q   <= job_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		job_d    = job_q;
		in_ready = 1'b0;
		cmd.op   = mwd_pkg::OP_NONE;
		cmd.cnt  = cnt_q;
		cmd.job  = job_q;
		case (state_q)
			mwd_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = mwd_pkg::OP_CAPTURE;
					state_d = mwd_pkg::ST_LOAD;
				end
			end
			mwd_pkg::ST_LOAD: begin
				cmd.op = mwd_pkg::OP_LOAD;
				cnt_d  = '0;
				state_d = sts.restart ? mwd_pkg::ST_DONE : mwd_pkg::ST_CORDIC;
			end
			mwd_pkg::ST_CORDIC: begin
				cmd.op = mwd_pkg::OP_CORDIC;
				if (cnt_q == mwd_pkg::CORDIC_LAST) begin
					state_d = mwd_pkg::ST_HEAD;
				end else begin
					cnt_d = cnt_q + 6'd1;
				end
			end
			mwd_pkg::ST_HEAD: begin
				cmd.op  = mwd_pkg::OP_HEAD;
				cnt_d   = '0;
				state_d = mwd_pkg::ST_MUL;
			end
			mwd_pkg::ST_MUL: begin
				cmd.op = mwd_pkg::OP_MUL;
				if (cnt_q == mwd_pkg::MUL_LAST) begin
					cnt_d   = '0;
					state_d = sts.arrived ? mwd_pkg::ST_DONE : mwd_pkg::ST_SQRT;
				end else begin
					cnt_d = cnt_q + 6'd1;
				end
			end
			mwd_pkg::ST_SQRT: begin
				cmd.op = mwd_pkg::OP_SQRT;
				if (cnt_q == mwd_pkg::SQRT_LAST) begin
					cnt_d   = '0;
					job_d   = '0;
					state_d = mwd_pkg::ST_DPREP;
				end else begin
					cnt_d = cnt_q + 6'd1;
				end
			end
			mwd_pkg::ST_KIN1: begin
				cmd.op  = mwd_pkg::OP_KIN1;
				state_d = mwd_pkg::ST_KIN2;
			end
			mwd_pkg::ST_KIN2: begin
				cmd.op  = mwd_pkg::OP_KIN2;
				state_d = mwd_pkg::ST_DPREP;
			end
			mwd_pkg::ST_DPREP: begin
				cmd.op  = mwd_pkg::OP_DPREP;
				cnt_d   = '0;
				state_d = mwd_pkg::ST_DIV;
			end
			mwd_pkg::ST_DIV: begin
				cmd.op = mwd_pkg::OP_DIV;
				if (cnt_q == mwd_pkg::DIV_LAST) begin
					state_d = mwd_pkg::ST_DSTORE;
				end else begin
					cnt_d = cnt_q + 6'd1;
				end
			end
			mwd_pkg::ST_DSTORE: begin
				cmd.op = mwd_pkg::OP_DSTORE;
				if (job_q == mwd_pkg::JOB_LAST) begin
					state_d = mwd_pkg::ST_DONE;
				end else begin
					job_d   = job_q + 3'd1;
					state_d = (job_q >= mwd_pkg::JOB_U1) ? mwd_pkg::ST_KIN1 :
						mwd_pkg::ST_DPREP;
				end
			end
			mwd_pkg::ST_DONE: begin
				if (!sts.out_busy) begin
					cmd.op  = mwd_pkg::OP_EMIT;
					state_d = mwd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mwd_pkg::ST_IDLE;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_accept_to_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mwd_pkg::ST_IDLE && in_valid) |=> (state_q == mwd_pkg::ST_LOAD))
		else $error("accepted transaction did not start the load step");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == mwd_pkg::OP_EMIT) |-> !sts.out_busy)
		else $error("result emitted over an unread result");
	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mwd_pkg::ST_DIV) |-> (cnt_q <= mwd_pkg::DIV_LAST))
		else $error("divider ran past its last quotient bit");
`endif

endmodule

// ----- hdl/mwd_datapath.sv -----
`timescale 1ns / 1ps
module mwd_datapath (
	input  logic           clk,
	input  logic           arst_n,
	input  mwd_pkg::cmd_t  cmd,
	output mwd_pkg::sts_t  sts,
	input  logic [63:0]    in_data,
	input  logic           in_user,
	input  logic           cfg_we,
	input  logic [1:0]     cfg_index,
	input  logic [29:0]    cfg_data,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [71:0]    out_data
);

	// Configuration and navigation state
	logic signed [15:0] tgt_x_q, tgt_y_q;
	logic signed [14:0] tgt_hd_q;
	logic [29:0] route_word_q, route_rem_q;
	logic route_loaded_q, last_arrived_q;
	logic [2:0] goal_q;

	// Item payload and working registers
	logic restart_q;
	logic signed [15:0] pos_x_q, pos_y_q, nx_q, ny_q;
	logic signed [25:0] cx_q, cy_q;
	logic signed [18:0] cz_q;
	logic turn_q, dir_q;
	logic signed [16:0] dx_q, dy_q;
	logic signed [50:0] prod_q, acc_q;
	logic [33:0] d2_q;
	logic [31:0] n2_q;
	logic signed [33:0] e0_q, e1_q;
	logic [63:0] sq_v_q, sq_r_q, sq_bit_q;
	logic signed [31:0] m_q;
	logic signed [35:0] num_q;
	logic [49:0] rem_q, dsh_q;
	logic [16:0] quo_q;
	logic neg_q;
	logic signed [17:0] u0_q, u1_q;
	logic signed [14:0] w_q [4];
	logic out_valid_q;
	logic [71:0] out_data_q;

	// Combinational intermediates
	logic [29:0] rem_src;
	logic [2:0] digit;
	logic signed [25:0] xs, ys, ysh, xsh;
	logic signed [18:0] tab, zr;
	logic signed [15:0] ang;
	logic signed [17:0] alpha, err, diff, v1, v2, v3;
	logic signed [16:0] gx, gy;
	logic signed [15:0] nxm;
	logic signed [17:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [50:0] prod;
	logic [63:0] sq_t;
	logic [31:0] dd;
	logic [32:0] dd_nz;
	logic [1:0] wi;
	logic signed [18:0] base;
	logic signed [31:0] ktv;
	logic signed [33:0] e_sel;
	logic [32:0] e_mag;
	logic [35:0] num_mag;
	logic [32:0] den;
	logic [49:0] div_n;
	logic [32:0] div_d;
	logic div_neg;
	logic [17:0] quo_s;
	logic arr_now;

	always_comb begin
		rem_src = route_loaded_q ? route_rem_q : (route_word_q & mwd_pkg::ROUTE_MASK);
		digit   = rem_src[2:0];

		// CORDIC start: scale by 256 and fold the left half plane
		xs = {{2{nx_q[15]}}, nx_q, 8'd0};
		ys = {{2{ny_q[15]}}, ny_q, 8'd0};
		ysh = cy_q >>> cmd.cnt[3:0];
		xsh = cx_q >>> cmd.cnt[3:0];
		tab = mwd_pkg::atan_q16(cmd.cnt[3:0]);

		zr    = cz_q + 19'sd8;
		ang   = 16'(-(zr >>> 4));
		alpha = 18'(tgt_hd_q);
		err   = alpha - 18'(ang);
		diff  = 18'(ang) - alpha;
		v1    = (diff < 0) ? diff + mwd_pkg::TWO_PI_Q12 : diff;
		v2    = (v1 < 0) ? v1 + mwd_pkg::TWO_PI_Q12 : v1;
		v3    = (v2 >= mwd_pkg::TWO_PI_Q12) ? v2 - mwd_pkg::TWO_PI_Q12 : v2;

		if (goal_q == 3'd0) begin
			gx = 17'(tgt_x_q);
			gy = 17'(tgt_y_q);
		end else begin
			gx = mwd_pkg::waypt_x(goal_q);
			gy = mwd_pkg::waypt_y(goal_q);
		end

		// A zero compass vector leaves the body frame equal to the world frame
		nxm = (nx_q == 16'sd0 && ny_q == 16'sd0) ? 16'sd1 : nx_q;
		case (cmd.cnt)
			6'd0: begin mul_a = 18'(dx_q); mul_b = 33'(dx_q); end
			6'd1: begin mul_a = 18'(dy_q); mul_b = 33'(dy_q); end
			6'd2: begin mul_a = 18'(nxm);  mul_b = 33'(nxm);  end
			6'd3: begin mul_a = 18'(ny_q); mul_b = 33'(ny_q); end
			6'd4: begin mul_a = 18'(dx_q); mul_b = 33'(nxm);  end
			6'd5: begin mul_a = 18'(dy_q); mul_b = 33'(ny_q); end
			6'd6: begin mul_a = 18'(dy_q); mul_b = 33'(nxm);  end
			6'd7: begin mul_a = 18'(dx_q); mul_b = 33'(ny_q); end
			6'd8: begin
				mul_a = signed'({1'b0, d2_q[16:0]});
				mul_b = signed'({1'b0, n2_q});
			end
			6'd9: begin
				mul_a = signed'({1'b0, d2_q[33:17]});
				mul_b = signed'({1'b0, n2_q});
			end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
		prod = 51'(mul_a) * 51'(mul_b);

		sq_t  = sq_r_q + sq_bit_q;
		dd    = sq_r_q[31:0];
		dd_nz = (dd == 32'd0) ? 33'd1 : {1'b0, dd};

		wi   = 2'(cmd.job - 3'd2);
		base = (wi == 2'd0 || wi == 2'd3) ? 19'(u0_q) - 19'(u1_q) : 19'(u0_q) + 19'(u1_q);
		ktv  = turn_q ? (dir_q ? mwd_pkg::K_TURN : -mwd_pkg::K_TURN) : 32'sd0;

		e_sel   = (cmd.job == 3'd0) ? e0_q : e1_q;
		e_mag   = 33'(e_sel[33] ? -e_sel : e_sel);
		num_mag = num_q[35] ? 36'(-num_q) : 36'(num_q);
		if (turn_q) begin
			den = (d2_q <= mwd_pkg::NEAR_D2) ? mwd_pkg::DEN_TURN_NEAR : mwd_pkg::DEN_TURN;
		end else begin
			den = (d2_q <= mwd_pkg::NEAR_D2) ? mwd_pkg::DEN_STILL_NEAR : mwd_pkg::DEN_STILL;
		end
		if (cmd.job <= mwd_pkg::JOB_U1) begin
			div_n   = {1'b0, e_mag, 16'd0} + 50'(dd_nz >> 1);
			div_d   = dd_nz;
			div_neg = e_sel[33];
		end else begin
			div_n   = 50'(num_mag) + 50'(den >> 1);
			div_d   = den;
			div_neg = num_q[35];
		end
		quo_s = neg_q ? -{1'b0, quo_q} : {1'b0, quo_q};

		arr_now = !restart_q && (d2_q <= mwd_pkg::ARRIVE_D2);
	end

	assign sts.restart  = restart_q;
	assign sts.arrived  = d2_q <= mwd_pkg::ARRIVE_D2;
	assign sts.out_busy = out_valid_q && !out_ready;
	assign out_valid    = out_valid_q;
	assign out_data     = out_data_q;

	// Configuration, navigation state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_x_q        <= '0;
			tgt_y_q        <= '0;
			tgt_hd_q       <= '0;
			route_word_q   <= '0;
			route_rem_q    <= '0;
			route_loaded_q <= 1'b0;
			last_arrived_q <= 1'b1;
			goal_q         <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					2'd0: tgt_x_q <= signed'(cfg_data[15:0]);
					2'd1: tgt_y_q <= signed'(cfg_data[15:0]);
					2'd2: tgt_hd_q <= signed'(cfg_data[14:0]);
					2'd3: route_word_q <= cfg_data;
					default: tgt_x_q <= tgt_x_q;
				endcase
			end
			if (cmd.op == mwd_pkg::OP_LOAD) begin
				if (restart_q) begin
					route_rem_q    <= '0;
					route_loaded_q <= 1'b0;
					last_arrived_q <= 1'b1;
					goal_q         <= '0;
				end else if (last_arrived_q) begin
					route_rem_q    <= rem_src >> 3;
					route_loaded_q <= 1'b1;
					goal_q         <= (digit <= mwd_pkg::LAST_WAYPOINT) ? digit : 3'd0;
				end
			end
			if (cmd.op == mwd_pkg::OP_EMIT) begin
				last_arrived_q <= restart_q ? 1'b1 : arr_now;
				out_valid_q    <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			mwd_pkg::OP_CAPTURE: begin
				restart_q <= in_user;
				pos_x_q   <= signed'(in_data[15:0]);
				pos_y_q   <= signed'(in_data[31:16]);
				nx_q      <= signed'(in_data[47:32]);
				ny_q      <= signed'(in_data[63:48]);
			end
			mwd_pkg::OP_LOAD: begin
				for (int k = 0; k < 4; k++) begin
					w_q[k] <= '0;
				end
				if (xs < 0) begin
					if (ys >= 0) begin
						cx_q <= ys;
						cy_q <= -xs;
						cz_q <= mwd_pkg::HALF_PI_Q16;
					end else begin
						cx_q <= -ys;
						cy_q <= xs;
						cz_q <= -mwd_pkg::HALF_PI_Q16;
					end
				end else begin
					cx_q <= xs;
					cy_q <= ys;
					cz_q <= '0;
				end
			end
			mwd_pkg::OP_CORDIC: begin
				if (cy_q > 0) begin
					cx_q <= cx_q + ysh;
					cy_q <= cy_q - xsh;
					cz_q <= cz_q + tab;
				end else if (cy_q < 0) begin
					cx_q <= cx_q - ysh;
					cy_q <= cy_q + xsh;
					cz_q <= cz_q - tab;
				end
			end
			mwd_pkg::OP_HEAD: begin
				turn_q <= (err > mwd_pkg::HEAD_TOL) || (err < -mwd_pkg::HEAD_TOL);
				dir_q  <= (v3 > 0) && (v3 < mwd_pkg::PI_Q12);
				dx_q   <= gx - 17'(pos_x_q);
				dy_q   <= gy - 17'(pos_y_q);
			end
			mwd_pkg::OP_MUL: begin
				prod_q <= prod;
				// Each product is folded in the cycle after it was formed
				case (cmd.cnt)
					6'd1, 6'd3, 6'd5, 6'd7, 6'd9: acc_q <= prod_q;
					6'd2: d2_q <= 34'(acc_q + prod_q);
					6'd4: n2_q <= 32'(acc_q + prod_q);
					6'd6: e0_q <= 34'(acc_q + prod_q);
					6'd8: e1_q <= 34'(acc_q - prod_q);
					6'd10: begin
						sq_v_q   <= 64'(acc_q) + (64'(prod_q) << 17);
						sq_r_q   <= '0;
						sq_bit_q <= 64'd1 << 62;
					end
					default: acc_q <= acc_q;
				endcase
			end
			mwd_pkg::OP_SQRT: begin
				if (sq_v_q >= sq_t) begin
					sq_v_q <= sq_v_q - sq_t;
					sq_r_q <= (sq_r_q >> 1) + sq_bit_q;
				end else begin
					sq_r_q <= sq_r_q >> 1;
				end
				sq_bit_q <= sq_bit_q >> 2;
			end
			mwd_pkg::OP_KIN1: begin
				m_q <= 32'(base) * mwd_pkg::KIN_GAIN + (wi[0] ? ktv : -ktv);
			end
			mwd_pkg::OP_KIN2: begin
				num_q <= 36'(m_q) * mwd_pkg::SPEED_NUM;
			end
			mwd_pkg::OP_DPREP: begin
				rem_q <= div_n;
				dsh_q <= {1'b0, div_d, 16'd0};
				quo_q <= '0;
				neg_q <= div_neg;
			end
			mwd_pkg::OP_DIV: begin
				if (rem_q >= dsh_q) begin
					rem_q <= rem_q - dsh_q;
					quo_q <= {quo_q[15:0], 1'b1};
				end else begin
					quo_q <= {quo_q[15:0], 1'b0};
				end
				dsh_q <= dsh_q >> 1;
			end
			mwd_pkg::OP_DSTORE: begin
				case (cmd.job)
					3'd0: u0_q <= signed'(quo_s);
					3'd1: u1_q <= signed'(quo_s);
					default: w_q[wi] <= signed'(quo_s[14:0]);
				endcase
			end
			mwd_pkg::OP_EMIT: begin
				out_data_q <= {7'd0, goal_q, arr_now && (goal_q == 3'd0), arr_now,
					w_q[3], w_q[2], w_q[1], w_q[0]};
			end
			default: begin
				neg_q <= neg_q;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_arrived_still: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q[60]) |-> (out_data_q[59:0] == 60'd0))
		else $error("wheel speeds not zero on an arrived result");
	a_done_final: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q[61]) |-> (out_data_q[60] && out_data_q[64:62] == 3'd0))
		else $error("route completion flagged away from the final target");
`endif

endmodule

// ----- hdl/mecanum_waypoint_drive_unit.sv -----
`timescale 1ns / 1ps
// Result path: a restart goes from capture and load straight to the done state; a tick
// at its goal adds CORDIC, heading and multiply; a driving tick runs every phase.
// Throughput: one item at a time; the next item is taken once the previous result is
// registered, so the rate is set by the 32-step square root and six 17-step divisions.
// Reset (arst_n low, asynchronous) clears the control, configuration and navigation
// registers, with the previous-arrival flag set so that the first tick takes the first
// route digit; the arithmetic working registers are loaded by each item before use.
module mecanum_waypoint_drive_unit (
	input  logic        clk,
	input  logic        arst_n,
	// Input items
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // pos_x[15:0], pos_y[31:16], north_x[47:32],
	                                   // north_y[63:48]
	input  logic [0:0]  s_axis_tuser,  // action[0]: 0 control tick, 1 restart
	// Result items
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,  // wheel_speed_1[14:0], wheel_speed_2[29:15],
	                                   // wheel_speed_3[44:30], wheel_speed_4[59:45],
	                                   // arrived[60], route_done[61], goal_index[64:62],
	                                   // zeros[71:65]
	// Register writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [29:0] cfg_data
);

	// The controller steps one item through heading, distance, square root, kinematics and
	// division phases; the datapath holds every arithmetic register and the result
	// register, so a finished result can wait while the next transaction is taken.
	mwd_pkg::cmd_t cmd;
	mwd_pkg::sts_t sts;

	// Writes are always taken; the host only writes while the unit is idle (unenforced).
	assign cfg_ready = 1'b1;

	mwd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mwd_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (s_axis_tdata),
		.in_user   (s_axis_tuser[0]),
		.cfg_we    (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule
